@@ rtl/polar_follow_velocity_controller_defines.svh @@
// Assertion macros for the checker file.
`ifndef POLAR_FOLLOW_VELOCITY_CONTROLLER_DEFINES_SVH
`define POLAR_FOLLOW_VELOCITY_CONTROLLER_DEFINES_SVH

// Checked at every clock edge, including the edges under reset.
`define PFVC_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("pfvc assertion failed");

// Checked only while the block is out of reset.
`define PFVC_ASSERT_RST(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("pfvc assertion failed under operation");

`endif

@@ rtl/pfvc_pkg.sv @@
package pfvc_pkg;

    // CORDIC coordinate width: Q.18 metres plus growth and sign.
    localparam int XW = 27;
    // Angle width: signed Q.20 radians.
    localparam int ZW = 25;

    localparam int ATAN_ENTRIES = 24;
    localparam int DEFAULT_CORDIC_STAGES = 16;

    localparam logic signed [ZW-1:0] PI_Q20 = 25'sd3294199;
    localparam logic [15:0] INV_K_Q16 = 16'd39797;

    localparam logic [15:0] LINEAR_GAIN_RESET   = 16'd8192;
    localparam logic [15:0] ANGULAR_GAIN_RESET  = 16'd9421;
    localparam logic [15:0] KEEP_DISTANCE_RESET = 16'd1229;
    localparam logic [15:0] MAX_DISTANCE_RESET  = 16'd2048;

    typedef enum logic [1:0] {
        REG_LINEAR_GAIN   = 2'd0,
        REG_ANGULAR_GAIN  = 2'd1,
        REG_KEEP_DISTANCE = 2'd2,
        REG_MAX_DISTANCE  = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [15:0] linear_gain;
        logic [15:0] angular_gain;
        logic [15:0] keep_distance;
        logic [15:0] max_distance;
    } cfg_t;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 orig;
    } vec_t;

    // atan(2^-i) in Q.20 radians, rounded to nearest.
    function automatic logic signed [ZW-1:0] atan_q20(input int i);
        logic signed [ZW-1:0] a;
        case (i)
            0:  a = 25'sd823550;
            1:  a = 25'sd486170;
            2:  a = 25'sd256879;
            3:  a = 25'sd130396;
            4:  a = 25'sd65451;
            5:  a = 25'sd32757;
            6:  a = 25'sd16383;
            7:  a = 25'sd8192;
            8:  a = 25'sd4096;
            9:  a = 25'sd2048;
            10: a = 25'sd1024;
            11: a = 25'sd512;
            12: a = 25'sd256;
            13: a = 25'sd128;
            14: a = 25'sd64;
            15: a = 25'sd32;
            16: a = 25'sd16;
            17: a = 25'sd8;
            18: a = 25'sd4;
            19: a = 25'sd2;
            20: a = 25'sd1;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

@@ rtl/pfvc_pre.sv @@
module pfvc_pre (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [15:0]   pos_x,
    input  logic signed [15:0]   pos_y,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pfvc_pkg::vec_t       out_vec
);

    logic           valid_reg;
    pfvc_pkg::vec_t vec_reg;
    pfvc_pkg::vec_t vec_next;
    logic           en;

    assign en = !valid_reg || out_ready;
    assign in_ready = en;

    always_comb begin
        logic signed [pfvc_pkg::XW-1:0] xs;
        logic signed [pfvc_pkg::XW-1:0] ys;
        xs = {{(pfvc_pkg::XW-24){pos_x[15]}}, pos_x, 8'd0};
        ys = {{(pfvc_pkg::XW-24){pos_y[15]}}, pos_y, 8'd0};
        vec_next.orig = (pos_x == 16'sd0) && (pos_y == 16'sd0);
        // Left half plane: rotate by pi first so the CORDIC converges.
        if (pos_x[15]) begin
            vec_next.x = -xs;
            vec_next.y = -ys;
            vec_next.z = pos_y[15] ? -pfvc_pkg::PI_Q20 : pfvc_pkg::PI_Q20;
        end else begin
            vec_next.x = xs;
            vec_next.y = ys;
            vec_next.z = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vec_reg <= vec_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

endmodule

@@ rtl/pfvc_cordic.sv @@
module pfvc_cordic #(
    parameter int CORDIC_STAGES = pfvc_pkg::DEFAULT_CORDIC_STAGES
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  pfvc_pkg::vec_t in_vec,
    output logic           out_valid,
    input  logic           out_ready,
    output pfvc_pkg::vec_t out_vec
);

    logic           valid_reg [CORDIC_STAGES];
    pfvc_pkg::vec_t vec_reg   [CORDIC_STAGES];
    logic           en        [CORDIC_STAGES];

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
        localparam logic signed [pfvc_pkg::ZW-1:0] ATAN = pfvc_pkg::atan_q20(k);

        pfvc_pkg::vec_t cur;
        pfvc_pkg::vec_t vec_next;
        logic           valid_in;
        logic           y_pos;

        if (k == 0) begin : g_first
            assign cur      = in_vec;
            assign valid_in = in_valid;
        end else begin : g_rest
            assign cur      = vec_reg[k-1];
            assign valid_in = valid_reg[k-1];
        end

        if (k == CORDIC_STAGES - 1) begin : g_last_en
            assign en[k] = !valid_reg[k] || out_ready;
        end else begin : g_mid_en
            assign en[k] = !valid_reg[k] || en[k+1];
        end

        assign y_pos = !cur.y[pfvc_pkg::XW-1] && (cur.y != '0);

        always_comb begin
            vec_next.orig = cur.orig;
            if (y_pos) begin
                vec_next.x = cur.x + (cur.y >>> k);
                vec_next.y = cur.y - (cur.x >>> k);
                vec_next.z = cur.z + ATAN;
            end else begin
                vec_next.x = cur.x - (cur.y >>> k);
                vec_next.y = cur.y + (cur.x >>> k);
                vec_next.z = cur.z - ATAN;
            end
            // A target at the origin keeps a bearing of zero.
            if (cur.orig) begin
                vec_next.z = cur.z;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en[k]) begin
                valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en[k]) begin
                vec_reg[k] <= vec_next;
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[CORDIC_STAGES-1];
    assign out_vec   = vec_reg[CORDIC_STAGES-1];

endmodule

@@ rtl/pfvc_post.sv @@
module pfvc_post (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pfvc_pkg::cfg_t       cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pfvc_pkg::vec_t       in_vec,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [15:0]          forward_speed,
    output logic signed [15:0]   turn_rate
);

    localparam int XUW = pfvc_pkg::XW - 1;       // final x is never negative
    localparam int PW  = XUW + 16;               // x * 1/K
    localparam int RW  = PW + 1 - 24;            // range in Q6.10
    localparam int FW  = RW + 16;                // diff * linear_gain
    localparam int TW  = pfvc_pkg::ZW + 17;      // bearing * angular_gain
    localparam int FSW = FW + 1 - 12;            // rounded forward speed
    localparam int TSW = TW + 1 - 22;            // rounded turn magnitude

    // Stage 1: range product.
    logic                          v1_reg;
    logic [PW-1:0]                 xprod_reg;
    logic signed [pfvc_pkg::ZW-1:0] z1_reg;
    // Stage 2: range check and distance error.
    logic                          v2_reg;
    logic                          near2_reg;
    logic [RW-1:0]                 diff2_reg;
    logic signed [pfvc_pkg::ZW-1:0] z2_reg;
    // Stage 3: gain products.
    logic                          v3_reg;
    logic                          near3_reg;
    logic [FW-1:0]                 fprod_reg;
    logic signed [TW-1:0]          tprod_reg;
    // Stage 4: rounded and saturated results.
    logic                          v4_reg;
    logic [15:0]                   fwd_reg;
    logic signed [15:0]            turn_reg;

    logic en1, en2, en3, en4;

    assign en4 = !v4_reg || out_ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_ready = en1;

    logic [PW:0]   rsum;
    logic [RW-1:0] range;
    logic          near;
    logic [RW-1:0] diff_next;

    assign rsum  = {1'b0, xprod_reg} + ((PW+1)'(1) << 23);
    assign range = rsum[PW:24];
    assign near  = range < RW'(cfg.max_distance);

    always_comb begin
        diff_next = '0;
        if (near && (range > RW'(cfg.keep_distance))) begin
            diff_next = range - RW'(cfg.keep_distance);
        end
    end

    logic [FW:0]     fsum;
    logic [FSW-1:0]  fwd_full;
    logic [15:0]     fwd_next;
    logic [TW-1:0]   tmag;
    logic [TW:0]     tsum;
    logic [TSW-1:0]  tmag_rnd;
    logic signed [15:0] turn_next;

    assign fsum     = {1'b0, fprod_reg} + (FW+1)'(2048);
    assign fwd_full = fsum[FW:12];
    assign tmag     = tprod_reg[TW-1] ? TW'(-tprod_reg) : TW'(tprod_reg);
    assign tsum     = {1'b0, tmag} + ((TW+1)'(1) << 21);
    assign tmag_rnd = tsum[TW:22];

    always_comb begin
        fwd_next  = '0;
        turn_next = '0;
        if (near3_reg) begin
            fwd_next = (fwd_full > FSW'(16'hFFFF)) ? 16'hFFFF : fwd_full[15:0];
            // Rounded half away from zero, then clipped to the signed range.
            if (tprod_reg[TW-1]) begin
                if (tmag_rnd > TSW'(17'd32768)) begin
                    turn_next = 16'sh8000;
                end else begin
                    turn_next = -$signed(tmag_rnd[15:0]);
                end
            end else begin
                if (tmag_rnd > TSW'(16'd32767)) begin
                    turn_next = 16'sh7FFF;
                end else begin
                    turn_next = $signed(tmag_rnd[15:0]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            xprod_reg <= PW'(in_vec.x[XUW-1:0]) * PW'(pfvc_pkg::INV_K_Q16);
            z1_reg    <= in_vec.z;
        end
        if (en2) begin
            near2_reg <= near;
            diff2_reg <= diff_next;
            z2_reg    <= z1_reg;
        end
        if (en3) begin
            near3_reg <= near2_reg;
            fprod_reg <= FW'(diff2_reg) * FW'(cfg.linear_gain);
            tprod_reg <= TW'(z2_reg) * TW'($signed({1'b0, cfg.angular_gain}));
        end
        if (en4) begin
            fwd_reg  <= fwd_next;
            turn_reg <= turn_next;
        end
    end

    assign out_valid     = v4_reg;
    assign forward_speed = fwd_reg;
    assign turn_rate     = turn_reg;

endmodule

@@ rtl/polar_follow_velocity_controller.sv @@
// Polar follow velocity controller.
// The s_ channel takes one target position per transaction; the m_ channel
// returns one forward speed and turn rate per transaction, in input order.
// The four gain and distance registers are written through cfg_we, cfg_addr
// and cfg_wdata; unknown indexes are ignored. The user must write them only
// while no transaction is in flight; the block does not enforce it. One stage
// folds the half plane, one CORDIC stage serves each iteration, and four
// stages do range scaling, range check, gain multiplication and rounding.
// Throughput is one transaction per cycle while m_tready stays high.
// Every stage has its own valid bit and moves whenever the stage after it is
// empty or moving, so a stall of m_tready holds the output and lets bubbles
// upstream fill; s_tready falls only when every stage holds an item.
// Reset clears all valid bits and loads the register defaults: gains 2.0 and
// 2.3, keep distance 1.2 m and maximum distance 2.0 m.
module polar_follow_velocity_controller #(
    parameter int CORDIC_STAGES = pfvc_pkg::DEFAULT_CORDIC_STAGES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // pos_x [15:0], pos_y [31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // forward_speed [15:0], turn_rate [31:16]
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    pfvc_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.linear_gain   <= pfvc_pkg::LINEAR_GAIN_RESET;
            cfg_reg.angular_gain  <= pfvc_pkg::ANGULAR_GAIN_RESET;
            cfg_reg.keep_distance <= pfvc_pkg::KEEP_DISTANCE_RESET;
            cfg_reg.max_distance  <= pfvc_pkg::MAX_DISTANCE_RESET;
        end else if (cfg_we) begin
            unique case (pfvc_pkg::reg_index_t'(cfg_addr))
                pfvc_pkg::REG_LINEAR_GAIN:   cfg_reg.linear_gain   <= cfg_wdata;
                pfvc_pkg::REG_ANGULAR_GAIN:  cfg_reg.angular_gain  <= cfg_wdata;
                pfvc_pkg::REG_KEEP_DISTANCE: cfg_reg.keep_distance <= cfg_wdata;
                pfvc_pkg::REG_MAX_DISTANCE:  cfg_reg.max_distance  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic           pre_valid, pre_ready;
    pfvc_pkg::vec_t pre_vec;
    logic           cor_valid, cor_ready;
    pfvc_pkg::vec_t cor_vec;
    logic [15:0]        forward_speed;
    logic signed [15:0] turn_rate;

    pfvc_pre u_pre (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .pos_x     ($signed(s_tdata[15:0])),
        .pos_y     ($signed(s_tdata[31:16])),
        .out_valid (pre_valid),
        .out_ready (pre_ready),
        .out_vec   (pre_vec)
    );

    pfvc_cordic #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (pre_valid),
        .in_ready  (pre_ready),
        .in_vec    (pre_vec),
        .out_valid (cor_valid),
        .out_ready (cor_ready),
        .out_vec   (cor_vec)
    );

    pfvc_post u_post (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .in_valid      (cor_valid),
        .in_ready      (cor_ready),
        .in_vec        (cor_vec),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .forward_speed (forward_speed),
        .turn_rate     (turn_rate)
    );

    assign m_tdata = {turn_rate, forward_speed};

endmodule

@@ rtl/pfvc_checker.sv @@
`include "polar_follow_velocity_controller_defines.svh"

module pfvc_checker #(
    parameter int CORDIC_STAGES = pfvc_pkg::DEFAULT_CORDIC_STAGES
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    localparam int DEPTH = CORDIC_STAGES + 5;
    localparam int CW    = $clog2(DEPTH + 2);

    // Number of transactions taken in but not yet delivered.
    logic [CW-1:0] inflight_reg;
    logic          s_fire, m_fire;

    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else if (s_fire && !m_fire) begin
            inflight_reg <= inflight_reg + CW'(1);
        end else if (m_fire && !s_fire) begin
            inflight_reg <= inflight_reg - CW'(1);
        end
    end

    `PFVC_ASSERT(a_reset_empties, !aresetn |=> !m_tvalid)
    `PFVC_ASSERT_RST(a_stall_holds, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    `PFVC_ASSERT_RST(a_no_phantom_result, m_tvalid |-> inflight_reg != '0)
    `PFVC_ASSERT_RST(a_ready_when_drained, m_tready |-> s_tready)

endmodule

bind polar_follow_velocity_controller pfvc_checker #(
    .CORDIC_STAGES (CORDIC_STAGES)
) u_pfvc_checker (.*);

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    localparam int STAGES = pfvc_pkg::DEFAULT_CORDIC_STAGES;
    localparam int PIPE_LATENCY = STAGES + 5;
    localparam int HOLDOFF_CYCLES = 80;
    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_PHASES = 6;
    localparam int ITEMS_PER_PHASE = 100;

    // atan(2^-i) in Q.20 radians; entries past 20 round to zero.
    localparam longint ATAN_STEP_Q20 [24] = '{
        823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
        4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8, 4, 2, 1, 0, 0, 0
    };

    typedef struct {
        logic [15:0]        forward_speed;
        logic signed [15:0] turn_rate;
    } velocity_cmd_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;     // pos_x [15:0], pos_y [31:16]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // forward_speed [15:0], turn_rate [31:16]
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [15:0] cfg_wdata = '0;

    // Register values as the block should hold them.
    logic [15:0] cfg_lin = pfvc_pkg::LINEAR_GAIN_RESET;
    logic [15:0] cfg_ang = pfvc_pkg::ANGULAR_GAIN_RESET;
    logic [15:0] cfg_keep = pfvc_pkg::KEEP_DISTANCE_RESET;
    logic [15:0] cfg_max = pfvc_pkg::MAX_DISTANCE_RESET;

    velocity_cmd_t pending_cmds[$];
    int          fail_count = 0;
    int unsigned cycle_count = 0;
    int unsigned burst_left = 0;
    bit          bursty = 1'b1;
    int unsigned holdoff_reqs = 0;

    polar_follow_velocity_controller dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic velocity_cmd_t predict_velocity(logic signed [15:0] px,
                                                       logic signed [15:0] py);
        longint x, y, z, xs, ys, rng, diff, fwd, prod, mag;
        int i;
        velocity_cmd_t cmd;
        x = longint'(px) * 256;
        y = longint'(py) * 256;
        z = 0;
        if (x != 0 || y != 0) begin
            // Fold the left half plane onto the right one.
            if (x < 0) begin
                z = (y >= 0) ? longint'(pfvc_pkg::PI_Q20) : -longint'(pfvc_pkg::PI_Q20);
                x = -x;
                y = -y;
            end
            for (i = 0; i < STAGES && i < 24; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0) begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ATAN_STEP_Q20[i];
                end else begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ATAN_STEP_Q20[i];
                end
            end
        end
        rng = (x * longint'(pfvc_pkg::INV_K_Q16) + 64'sd8388608) >>> 24;
        cmd.forward_speed = '0;
        cmd.turn_rate = '0;
        if (rng < longint'(cfg_max)) begin
            diff = (rng > longint'(cfg_keep)) ? rng - longint'(cfg_keep) : 0;
            fwd = (diff * longint'(cfg_lin) + 2048) >>> 12;
            cmd.forward_speed = (fwd > 65535) ? 16'hFFFF : fwd[15:0];
            prod = z * longint'(cfg_ang);
            mag = (prod < 0) ? -prod : prod;
            mag = (mag + 64'sd2097152) >>> 22;
            if (prod < 0) begin
                if (mag > 32768) mag = 32768;
                cmd.turn_rate = 16'(-mag);
            end else begin
                if (mag > 32767) mag = 32767;
                cmd.turn_rate = 16'(mag);
            end
        end
        return cmd;
    endfunction

    // Receiver: changing stall patterns, plus long hold-offs on request.
    int unsigned holdoff_served = 0;
    int unsigned holdoff_left = 0;
    int unsigned pattern_left = 0;
    int unsigned stall_pct = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (holdoff_left != 0) begin
            holdoff_left--;
            m_tready <= 1'b0;
        end else if (holdoff_reqs != holdoff_served) begin
            holdoff_served++;
            holdoff_left = HOLDOFF_CYCLES;
            m_tready <= 1'b0;
        end else begin
            if (pattern_left == 0) begin
                pattern_left = $urandom_range(10, 60);
                case ($urandom_range(0, 4))
                    0, 1: stall_pct = 0;
                    2: stall_pct = 25;
                    3: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            pattern_left--;
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        velocity_cmd_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_cmds.size() == 0) begin
                $error("result transaction with nothing expected: %h", m_tdata);
                fail_count++;
            end else begin
                want = pending_cmds.pop_front();
                if (m_tdata[15:0] !== want.forward_speed) begin
                    $error("forward_speed: expected %0d, got %0d",
                           want.forward_speed, m_tdata[15:0]);
                    fail_count++;
                end
                if (m_tdata[31:16] !== want.turn_rate) begin
                    $error("turn_rate: expected %0d, got %0d",
                           want.turn_rate, $signed(m_tdata[31:16]));
                    fail_count++;
                end
            end
        end
    end

    task automatic send_pos(input logic signed [15:0] px, input logic signed [15:0] py);
        velocity_cmd_t want;
        want = predict_velocity(px, py);
        s_tvalid <= 1'b1;
        s_tdata <= {py, px};
        do @(posedge aclk); while (!s_tready);
        pending_cmds = {pending_cmds, want};
        if (bursty) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(0, 30);
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge aclk);
        repeat (PIPE_LATENCY + 8) @(posedge aclk);
    endtask

    // Only called while nothing is in flight.
    task automatic write_settings(input logic [15:0] lin, input logic [15:0] ang,
                                  input logic [15:0] keep, input logic [15:0] maxd);
        cfg_we <= 1'b1;
        cfg_addr <= pfvc_pkg::REG_LINEAR_GAIN;
        cfg_wdata <= lin;
        @(posedge aclk);
        cfg_addr <= pfvc_pkg::REG_ANGULAR_GAIN;
        cfg_wdata <= ang;
        @(posedge aclk);
        cfg_addr <= pfvc_pkg::REG_KEEP_DISTANCE;
        cfg_wdata <= keep;
        @(posedge aclk);
        cfg_addr <= pfvc_pkg::REG_MAX_DISTANCE;
        cfg_wdata <= maxd;
        @(posedge aclk);
        cfg_we <= 1'b0;
        cfg_lin = lin;
        cfg_ang = ang;
        cfg_keep = keep;
        cfg_max = maxd;
    endtask

    task automatic pick_target(output logic signed [15:0] px,
                               output logic signed [15:0] py);
        int r;
        r = (cfg_max > 32767) ? 32767 : int'(cfg_max);
        if (r < 64) r = 64;
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9: begin
                px = 16'(int'($urandom_range(0, 2 * r)) - r);
                py = 16'(int'($urandom_range(0, 2 * r)) - r);
            end
            10, 11, 12, 13, 14: begin
                px = 16'($urandom_range(0, 65535));
                py = 16'($urandom_range(0, 65535));
            end
            15, 16, 17: begin
                case ($urandom_range(0, 4))
                    0: px = 16'sh8000;
                    1: px = -16'sd1;
                    2: px = 16'sd0;
                    3: px = 16'sd1;
                    default: px = 16'sd32767;
                endcase
                py = 16'($urandom_range(0, 65535));
                if ($urandom_range(0, 1)) begin
                    r = px;
                    px = py;
                    py = 16'(r);
                end
            end
            default: begin
                px = 16'(int'($urandom_range(0, 32)) - 16);
                py = 16'(int'($urandom_range(0, 32)) - 16);
            end
        endcase
    endtask

    // Reset settings: origin, both half planes, axes, too close and too far.
    task automatic test_default_geometry();
        send_pos(0, 0);
        send_pos(1536, 0);
        send_pos(1024, 0);
        send_pos(4096, 0);
        send_pos(-1024, 0);
        send_pos(-1024, 512);
        send_pos(-1024, -512);
        send_pos(0, 1024);
        send_pos(0, -1024);
        send_pos(1000, 800);
        send_pos(-900, -1200);
        send_pos(1229, 0);
        drain_pipeline();
    endtask

    // Largest gains, no keep distance, nothing ignored: both fields saturate for some targets.
    task automatic test_extreme_positions();
        write_settings(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF);
        send_pos(32767, 32767);
        send_pos(-32768, -32768);
        send_pos(-32768, 32767);
        send_pos(32767, -32768);
        send_pos(-32768, 0);
        send_pos(0, -32768);
        send_pos(0, 32767);
        send_pos(1, 0);
        send_pos(-1, 0);
        send_pos(0, 1);
        send_pos(-1, -1);
        drain_pipeline();
    endtask

    // A zero maximum distance ignores every target, even at the origin.
    task automatic test_zero_settings();
        write_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_pos(0, 0);
        send_pos(-32768, 32767);
        send_pos(100, -100);
        drain_pipeline();
    endtask

    // The receiver holds off long enough for the pipeline to back up.
    task automatic test_output_holdoff();
        logic signed [15:0] px, py;
        write_settings(16'd6000, 16'd12000, 16'd512, 16'hFFFF);
        bursty = 1'b0;
        holdoff_reqs++;
        repeat (60) begin
            pick_target(px, py);
            send_pos(px, py);
        end
        bursty = 1'b1;
        drain_pipeline();
    endtask

    task automatic test_random_targets();
        logic signed [15:0] px, py;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: write_settings(pfvc_pkg::LINEAR_GAIN_RESET, pfvc_pkg::ANGULAR_GAIN_RESET,
                                  pfvc_pkg::KEEP_DISTANCE_RESET,
                                  pfvc_pkg::MAX_DISTANCE_RESET);
                1: write_settings(16'($urandom_range(0, 65535)),
                                  16'($urandom_range(0, 65535)),
                                  16'($urandom_range(0, 4096)), 16'hFFFF);
                2: write_settings(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF);
                3: write_settings(16'($urandom_range(0, 8192)),
                                  16'($urandom_range(0, 8192)),
                                  16'($urandom_range(0, 65535)),
                                  16'($urandom_range(0, 65535)));
                4: write_settings(16'd1, 16'd1, 16'hFFFF, 16'hFFFF);
                default: write_settings(16'($urandom_range(0, 65535)),
                                        16'($urandom_range(0, 65535)),
                                        16'($urandom_range(0, 65535)),
                                        16'($urandom_range(0, 65535)));
            endcase
            repeat (ITEMS_PER_PHASE) begin
                pick_target(px, py);
                send_pos(px, py);
                if ($urandom_range(0, 99) < 3) drain_pipeline();
            end
            drain_pipeline();
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_default_geometry();
        test_extreme_positions();
        test_zero_settings();
        test_output_holdoff();
        test_random_targets();
        drain_pipeline();
        if (pending_cmds.size() != 0) begin
            $error("%0d results never arrived", pending_cmds.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
